>>> rtl/arx_matrix_hash_512_defines.svh
// Assertion macros used by amh_control.
`ifndef ARX_MATRIX_HASH_512_DEFINES_SVH
`define ARX_MATRIX_HASH_512_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold on the same edge.
`define AMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Whenever the antecedent holds, the consequent must hold on the next edge.
`define AMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/amh_pkg.sv
`default_nettype none
package amh_pkg;

  localparam int unsigned RoundCountDefault = 20;
  localparam int unsigned WordW = 64;
  localparam int unsigned DigestBitsW = 10;
  localparam int unsigned FinalBitsW = 11;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [15:0] matrix_t;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StFinish,
    StEmit
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_word;     // store the accepted beat in the block buffer
    logic start;         // copy the chain value into the working matrix
    logic round_step;    // run one half round
    logic inject;        // message injection in this half round
    logic inject_hi;     // use buffer words 8..15 instead of 0..7
    logic tail_step;     // second half round: XOR in constants
    logic [2:0] rc_group;
    logic feed_forward;  // fold the working matrix into the chain value
    logic reinit;        // restore the initial value and clear the count
    logic last_flag;
  } dp_cmd_t;

  localparam word_t [3:0] BaseRc = '{
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
    64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  localparam matrix_t InitValue = '{
    64'h636920d871574e69, 64'h0801f2e2858efc16, 64'h24a19947b3916cf7, 64'hba7c9045f12c7f99,
    64'hb8e1afed6a267e96, 64'h2ffd72dbd01adfb7, 64'hd1310ba698dfb5ac, 64'h9216d5d98979fb1b,
    64'h3f84d5b5b5470917, 64'hc0ac29b7c97c50dd, 64'hbe5466cf34e90c6c, 64'h452821e638d01377,
    64'h082efa98ec4e6c89, 64'ha4093822299f31d0, 64'h13198a2e03707344, 64'h243f6a8885a308d3
  };

  function automatic word_t ror64(word_t x, int unsigned n);
    ror64 = (x >> n) | (x << (WordW - n));
  endfunction

  // Column ARX map followed by the row rotation.
  function automatic matrix_t half_round(matrix_t s);
    matrix_t t;
    word_t a, b, x, d;
    t = s;
    for (int c = 0; c < 4; c++) begin
      a = s[c]; b = s[4+c]; x = s[8+c]; d = s[12+c];
      a = a + b;
      x = x + d;
      d = ror64(d ^ a, 8);
      x = x + (d ^ ror64(d, 5) ^ ror64(d, 48));
      b = ror64(b ^ x, 63);
      a = a + (b ^ ror64(b, 11) ^ ror64(b, 40));
      t[c] = a; t[4+c] = b; t[8+c] = x; t[12+c] = d;
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        half_round[r*4+c] = t[r*4+((c+r)%4)];
      end
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/amh_stream_if.sv
`default_nettype none
interface amh_in_if;
  logic                                valid;
  logic                                ready;
  logic [amh_pkg::WordW-1:0]           message_word;
  logic                                end_of_message;
  logic [amh_pkg::FinalBitsW-1:0]      final_block_bits;
  modport source (output valid, message_word, end_of_message, final_block_bits, input ready);
  modport sink (input valid, message_word, end_of_message, final_block_bits, output ready);
endinterface

interface amh_out_if;
  logic                      valid;
  logic                      ready;
  logic [amh_pkg::WordW-1:0] digest_word;
  logic [2:0]                word_index;
  logic                      last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

>>> rtl/arx_matrix_hash_512.sv
`default_nettype none
// 512-bit ARX matrix hash. Message words arrive one per beat on in_if; 16 words
// form a block, and the beat with end_of_message closes the message. A beat is
// taken whenever one is valid while the buffer fills; the beat closing a block
// starts a compression (one half round per cycle in a single shared round unit,
// followed by a feed-forward step), during which no beat is taken. After the
// last block the digest leaves on out_if as 1 to 8 words, one per cycle while
// out_if.ready is high, and the core returns to its initial value. Write
// digest_bits only while the core is idle.
module arx_matrix_hash_512 #(
  parameter int unsigned RoundCount = amh_pkg::RoundCountDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  amh_in_if.sink                               in_if,
  amh_out_if.source                            out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [amh_pkg::DigestBitsW-1:0] cfg_wdata_i
);

  logic [amh_pkg::DigestBitsW-1:0] digest_bits_q;
  amh_pkg::dp_cmd_t cmd;
  logic [3:0] fill_idx;
  logic [amh_pkg::WordW-1:0] chain_word;

  // Digest length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digest_bits_q <= 10'd512;
    end else if (cfg_we_i) begin
      digest_bits_q <= cfg_wdata_i;
    end
  end

  amh_control #(.RoundCount(RoundCount)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_eom_i(in_if.end_of_message), .in_ready_o(in_if.ready),
    .digest_bits_i(digest_bits_q), .chain_word_i(chain_word),
    .out_ready_i(out_if.ready), .out_valid_o(out_if.valid),
    .out_word_o(out_if.digest_word), .out_idx_o(out_if.word_index),
    .out_last_o(out_if.last_word), .fill_idx_o(fill_idx), .cmd_o(cmd)
  );

  amh_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .fill_idx_i(fill_idx),
    .word_i(in_if.message_word), .eom_i(in_if.end_of_message),
    .fbits_i(in_if.final_block_bits), .out_idx_i(out_if.word_index),
    .chain_word_o(chain_word)
  );

endmodule
`default_nettype wire

>>> rtl/amh_datapath.sv
`default_nettype none
module amh_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire amh_pkg::dp_cmd_t               cmd_i,
  input  wire logic [3:0]                     fill_idx_i,
  input  wire logic [amh_pkg::WordW-1:0]      word_i,
  input  wire logic                           eom_i,
  input  wire logic [amh_pkg::FinalBitsW-1:0] fbits_i,
  input  wire logic [2:0]                     out_idx_i,
  output      logic [amh_pkg::WordW-1:0]      chain_word_o
);

  amh_pkg::matrix_t chain_q, chain_d, work_q, work_d, buf_q;
  logic [amh_pkg::WordW-1:0] cnt_lo_q, cnt_lo_d, cnt_hi_q, cnt_hi_d, add_v;
  logic [amh_pkg::WordW:0] sum;
  amh_pkg::matrix_t s;
  amh_pkg::word_t [3:0] tail;

  // Block buffer; words beyond the last one of a final block are zero-filled.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      for (int k = 0; k < 16; k++) begin
        if (4'(k) == fill_idx_i) begin
          buf_q[k] <= word_i;
        end else if (eom_i && 4'(k) > fill_idx_i) begin
          buf_q[k] <= '0;
        end
      end
    end
  end

  // Bit count update on the beat that closes a block.
  always_comb begin
    add_v = eom_i ? ((fbits_i > 11'd1024) ? 64'd1024 : 64'(fbits_i)) : 64'd1024;
    sum = {1'b0, cnt_lo_q} + {1'b0, add_v};
    cnt_lo_d = cnt_lo_q;
    cnt_hi_d = cnt_hi_q;
    if (cmd_i.reinit) begin
      cnt_lo_d = '0;
      cnt_hi_d = '0;
    end else if (cmd_i.load_word && (eom_i || fill_idx_i == 4'd15)) begin
      cnt_lo_d = sum[amh_pkg::WordW-1:0];
      cnt_hi_d = cnt_hi_q + 64'(sum[amh_pkg::WordW]);
    end
  end

  // One half round per cycle on the working matrix, plus the start copy and the chain value update.
  always_comb begin
    tail[0] = 64'h200;
    tail[1] = cmd_i.last_flag ? '1 : '0;
    tail[2] = cnt_hi_q;
    tail[3] = cnt_lo_q;
    s = work_q;
    if (cmd_i.inject) begin
      for (int c = 0; c < 4; c++) begin
        s[c]   = s[c]   ^ (cmd_i.inject_hi ? buf_q[8+c]  : buf_q[c]);
        s[8+c] = s[8+c] ^ (cmd_i.inject_hi ? buf_q[12+c] : buf_q[4+c]);
      end
    end
    s = amh_pkg::half_round(s);
    if (cmd_i.tail_step) begin
      for (int c = 0; c < 4; c++) begin
        s[4+c]  = s[4+c]  ^ amh_pkg::BaseRc[2'(32'(cmd_i.rc_group) + c)];
        s[12+c] = s[12+c] ^ tail[c];
      end
    end
    work_d = work_q;
    if (cmd_i.start) begin
      work_d = chain_q;
    end else if (cmd_i.round_step) begin
      work_d = s;
    end
    chain_d = chain_q;
    if (cmd_i.reinit) begin
      chain_d = amh_pkg::InitValue;
    end else if (cmd_i.feed_forward) begin
      chain_d = chain_q ^ work_q;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q  <= amh_pkg::InitValue;
      cnt_lo_q <= '0;
      cnt_hi_q <= '0;
    end else begin
      chain_q  <= chain_d;
      cnt_lo_q <= cnt_lo_d;
      cnt_hi_q <= cnt_hi_d;
    end
  end

  // The digest comes from rows 0 and 1 only.
  assign chain_word_o = chain_q[{1'b0, out_idx_i}];

endmodule
`default_nettype wire

>>> rtl/amh_control.sv
`default_nettype none
`include "arx_matrix_hash_512_defines.svh"
module amh_control #(
  parameter int unsigned RoundCount = amh_pkg::RoundCountDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_eom_i,
  output      logic                            in_ready_o,
  input  wire logic [amh_pkg::DigestBitsW-1:0] digest_bits_i,
  input  wire logic [amh_pkg::WordW-1:0]       chain_word_i,
  input  wire logic                            out_ready_i,
  output      logic                            out_valid_o,
  output      logic [amh_pkg::WordW-1:0]       out_word_o,
  output      logic [2:0]                      out_idx_o,
  output      logic                            out_last_o,
  output      logic [3:0]                      fill_idx_o,
  output      amh_pkg::dp_cmd_t                cmd_o
);

  localparam int unsigned HalfSteps = 2 * RoundCount;
  localparam int unsigned StepW = $clog2(HalfSteps);

  amh_pkg::state_e state_q, state_d;
  logic [3:0] fill_q, fill_d;
  logic [StepW-1:0] step_q, step_d;
  logic last_q, last_d;
  logic [2:0] idx_q, idx_d;
  logic [9:0] dbits;
  logic [6:0] nbytes;
  logic [2:0] last_idx;
  logic [63:0] mask;
  logic [4:0] rnd;
  logic [StepW:0] step_ext;

  // Clamp the requested length, work out the byte and word counts and the byte mask.
  always_comb begin
    dbits = digest_bits_i;
    if (dbits == '0) dbits = 10'd1;
    if (dbits > 10'd512) dbits = 10'd512;
    nbytes = 7'((dbits + 10'd7) >> 3);
    last_idx = 3'((nbytes - 7'd1) >> 3);
    for (int b = 0; b < 8; b++) begin
      if ({idx_q, 3'(b)} < 6'(nbytes - 7'd1)) begin
        mask[b*8 +: 8] = 8'hff;
      end else if ({idx_q, 3'(b)} == 6'(nbytes - 7'd1)) begin
        mask[b*8 +: 8] = (dbits[2:0] == 3'd0) ? 8'hff : 8'(8'hff << (4'd8 - 4'(dbits[2:0])));
      end else begin
        mask[b*8 +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    step_d = step_q;
    last_d = last_q;
    idx_d = idx_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    step_ext = {1'b0, step_q};
    rnd = 5'(step_ext >> 1);
    cmd_o.last_flag = last_q;
    unique case (state_q)
      amh_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_word = 1'b1;
          fill_d = fill_q + 4'd1;
          if (in_eom_i || fill_q == 4'd15) begin
            cmd_o.start = 1'b1;
            last_d = in_eom_i;
            step_d = '0;
            fill_d = '0;
            state_d = amh_pkg::StRound;
          end
        end
      end
      amh_pkg::StRound: begin
        cmd_o.round_step = 1'b1;
        cmd_o.inject = (rnd[1:0] == 2'd0);
        cmd_o.inject_hi = step_q[0];
        cmd_o.tail_step = step_q[0];
        // With the default of 20 rounds the group index never exceeds four.
        cmd_o.rc_group = 3'(rnd >> 2);
        if (32'(step_q) == HalfSteps - 1) begin
          state_d = amh_pkg::StFinish;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      amh_pkg::StFinish: begin
        cmd_o.feed_forward = 1'b1;
        idx_d = '0;
        state_d = last_q ? amh_pkg::StEmit : amh_pkg::StIdle;
      end
      amh_pkg::StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == last_idx) begin
            cmd_o.reinit = 1'b1;
            state_d = amh_pkg::StIdle;
          end
        end
      end
      default: state_d = amh_pkg::StIdle;
    endcase
  end

  assign fill_idx_o = fill_q;
  assign out_word_o = chain_word_i & mask;
  assign out_idx_o = idx_q;
  assign out_last_o = (idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amh_pkg::StIdle;
      fill_q <= '0;
      step_q <= '0;
      last_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      step_q <= step_d;
      last_q <= last_d;
      idx_q <= idx_d;
    end
  end

  `AMH_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != amh_pkg::StIdle, !in_ready_o)
  `AMH_ASSERT_IMP(a_emit_last_only, clk_i, rst_ni, out_valid_o, last_q)
  `AMH_ASSERT_NEXT(a_block_starts_rounds, clk_i, rst_ni, cmd_o.start, state_q == amh_pkg::StRound && step_q == '0)

endmodule
`default_nettype wire
